@@ hdl/length_checked_frame_receiver_macros.svh @@
// Assertion macros shared by the frame receiver RTL.
`ifndef LENGTH_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lcfr_pkg.sv @@
// Shared constants, types and helpers of the frame receiver.
`default_nettype none

package lcfr_pkg;

  // Frame overhead: size byte, complement byte and checksum byte.
  localparam logic [7:0] OVERHEAD = 8'd3;
  localparam logic [7:0] ALL_ONES = 8'hFF;
  localparam logic [7:0] MAX_FRAME_SIZE_RST = 8'd255;

  // Event codes carried in the kind field of a result word.
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_len;
  } lcfr_event_t;

  // A size byte may start a frame only inside [OVERHEAD, max_size).
  function automatic logic size_ok(input logic [7:0] s, input logic [7:0] max_size);
    return (s >= OVERHEAD) && (s < max_size);
  endfunction

endpackage

`default_nettype wire

@@ hdl/length_checked_frame_receiver.sv @@
// A word taken into the input register is stepped by the deframer; any result
// is captured in the result register. Throughput: one word per cycle; the input
// register, the deframer step and the result register form a two-stage pipeline
// that stalls only on out_ready_i. Frame checks use 8-bit adds and compares.
// Reset (rst_ni low, asynchronous): pipeline empty, deframer idle, limit 255.
`default_nettype none

module length_checked_frame_receiver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      event_kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      frame_len_o
);
  import lcfr_pkg::*;

`include "length_checked_frame_receiver_macros.svh"

  logic [7:0]  max_frame_size_q;
  logic        in_valid_q;
  logic [7:0]  rx_q;
  logic        out_valid_q;
  lcfr_event_t out_q;
  logic        advance;
  logic        step;
  logic        res_valid;
  lcfr_event_t res;

  // The result register can take a new word when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_size_q <= MAX_FRAME_SIZE_RST;
    end else if (cfg_we_i) begin
      max_frame_size_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q <= rx_data_i;
    end
  end

  lcfr_deframer u_deframer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .rx_data_i        (rx_q),
    .max_frame_size_i (max_frame_size_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_q.kind;
  assign data_byte_o  = out_q.data_byte;
  assign byte_index_o = out_q.byte_index;
  assign frame_len_o  = out_q.frame_len;

  // Result word consistency.
  `LCFR_ASSERT_NOW(a_kind_legal, out_valid_q,
                   (out_q.kind == EV_PAYLOAD) || (out_q.kind == EV_ACCEPT) ||
                   (out_q.kind == EV_REJECT), "illegal event kind")
  `LCFR_ASSERT_NOW(a_end_fields, out_valid_q && (out_q.kind != EV_PAYLOAD),
                   (out_q.data_byte == 8'd0) && (out_q.byte_index == 8'd0),
                   "frame end word carries payload fields")
  `LCFR_ASSERT_NOW(a_payload_fields, out_valid_q && (out_q.kind == EV_PAYLOAD),
                   out_q.frame_len == 8'd0, "payload word carries a length")
  `LCFR_ASSERT_NEXT(a_step_drains, in_valid_q && advance && !(in_ready_o && in_valid_i),
                    !in_valid_q, "processed word left in the input register")

endmodule

`default_nettype wire

@@ hdl/lcfr_deframer.sv @@
// Deframer state and the combinational step for one received word.
`default_nettype none

module lcfr_deframer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         rx_data_i,
  input  wire logic [7:0]         max_frame_size_i,
  output logic                    res_valid_o,
  output lcfr_pkg::lcfr_event_t   res_o
);
  import lcfr_pkg::*;

`include "length_checked_frame_receiver_macros.svh"

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_CHECK  = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] size_q, size_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;
  logic [7:0] payload_len;

  assign payload_len = size_q - OVERHEAD;

  // Next state and result for the word presented this cycle.
  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    sum_d       = sum_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_CHECK: begin
        if (((sum_q ^ rx_data_i) == ALL_ONES) && size_ok(sum_q, max_frame_size_i)) begin
          sum_d   = sum_q + rx_data_i;
          count_d = '0;
          phase_d = PH_DATA;
        end else begin
          // The failed check word becomes the next candidate size.
          sum_d  = rx_data_i;
          size_d = rx_data_i;
        end
      end
      PH_DATA: begin
        res_valid_o = 1'b1;
        if (count_q == payload_len) begin
          res_o.kind      = (sum_q == rx_data_i) ? EV_ACCEPT : EV_REJECT;
          res_o.frame_len = count_q;
          phase_d         = PH_IDLE;
        end else begin
          res_o.kind       = EV_PAYLOAD;
          res_o.data_byte  = rx_data_i;
          res_o.byte_index = count_q;
          sum_d            = sum_q + rx_data_i;
          count_d          = count_q + 8'd1;
        end
      end
      default: begin
        // Idle, and the unused code behaves as idle.
        phase_d = PH_IDLE;
        if (size_ok(rx_data_i, max_frame_size_i)) begin
          size_d  = rx_data_i;
          sum_d   = rx_data_i;
          phase_d = PH_CHECK;
        end
      end
    endcase
  end

  // State registers advance only when a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      size_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // Consistency of the frame state.
  `LCFR_ASSERT_NOW(a_phase_used, 1'b1, phase_q != PH_UNUSED, "deframer reached unused phase")
  `LCFR_ASSERT_NOW(a_check_sum, phase_q == PH_CHECK, sum_q == size_q,
                   "candidate size and running sum disagree")
  `LCFR_ASSERT_NOW(a_count_bound, phase_q == PH_DATA, count_q <= payload_len,
                   "payload count ran past frame length")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the length-checked frame receiver: directed and random frames against a predictor.
`timescale 1ns / 1ps

module tb;
  import lcfr_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 200;

  // Deframer phases as the predictor tracks them.
  typedef enum logic [1:0] {
    RX_IDLE   = 2'd0,
    RX_CHECK  = 2'd1,
    RX_DATA   = 2'd2,
    RX_UNUSED = 2'd3
  } rx_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_data_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] event_kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic [7:0] frame_len_o;

  // Predictor state and its copy of the size limit.
  rx_phase_e  phase_m = RX_IDLE;
  logic [7:0] size_m = 8'd0;
  logic [7:0] sum_m = 8'd0;
  logic [7:0] count_m = 8'd0;
  logic [7:0] max_size_m = MAX_FRAME_SIZE_RST;

  lcfr_event_t pending_events[$];
  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  bit          idling_on = 1'b1;
  bit          hold_request = 1'b0;

  length_checked_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_data_i       (rx_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .frame_len_o     (frame_len_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idling_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic starts_frame(input logic [7:0] s);
    return (s >= OVERHEAD) && (s < max_size_m);
  endfunction

  // Advance the predictor by one received word and queue the event it causes.
  task automatic deframe_byte(input logic [7:0] b);
    lcfr_event_t ev;
    logic [7:0]  len;
    ev = '0;
    len = size_m - OVERHEAD;
    case (phase_m)
      RX_CHECK: begin
        if ((sum_m ^ b) == ALL_ONES && starts_frame(sum_m)) begin
          sum_m = sum_m + b;
          count_m = 8'd0;
          phase_m = RX_DATA;
        end else begin
          // A failed complement becomes the next candidate size.
          sum_m = b;
          size_m = b;
        end
      end
      RX_DATA: begin
        if (count_m == len) begin
          ev.kind = (sum_m == b) ? EV_ACCEPT : EV_REJECT;
          ev.frame_len = count_m;
          phase_m = RX_IDLE;
        end else begin
          sum_m = sum_m + b;
          ev.kind = EV_PAYLOAD;
          ev.data_byte = b;
          ev.byte_index = count_m;
          count_m = count_m + 8'd1;
        end
        pending_events.push_back(ev);
      end
      default: begin
        phase_m = RX_IDLE;
        if (starts_frame(b)) begin
          size_m = b;
          sum_m = b;
          phase_m = RX_CHECK;
        end
      end
    endcase
  endtask

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    deframe_byte(b);
  endtask

  // Size, complement, random payload and a good or corrupted checksum.
  task automatic send_frame(input logic [7:0] s, input bit good_sum);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned k;
    // Size plus its complement always sums to all ones.
    sum = ALL_ONES;
    send_byte(s);
    send_byte(~s);
    for (k = 3; k < s; k++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Stop offering words, let every expected event arrive, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_size(input logic [7:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    max_size_m = v;
  endtask

  task automatic test_short_sizes_ignored();
    send_byte(8'd0);
    send_byte(8'd1);
    send_byte(8'd2);
  endtask

  // Two payload words at the value extremes; the checksum wraps to 0xFE.
  task automatic test_payload_extremes();
    send_byte(8'd5);
    send_byte(8'hFA);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFE);
  endtask

  // At the reset limit a size of 255 is dropped; then an empty frame with a bad checksum.
  task automatic test_oversize_ignored();
    send_byte(8'hFF);
    send_frame(8'd3, 1'b0);
  endtask

  // Wrong complements chain through out-of-range candidates before a valid empty frame.
  task automatic test_complement_mismatch();
    send_byte(8'd9);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd3, 1'b1);
  endtask

  // Smallest limit: only a size of 3 may start a frame.
  task automatic test_min_limit();
    write_max_size(8'd4);
    send_byte(8'd4);
    send_frame(8'd3, 1'b1);
    write_max_size(MAX_FRAME_SIZE_RST);
  endtask

  // The receiver holds off while frames keep coming, so the block must stall its input.
  task automatic test_long_hold();
    int unsigned k;
    wait_drained();
    idling_on = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 12; k++) send_frame(8'd6, k[0]);
    idling_on = 1'b1;
  endtask

  // Phases of random traffic, each under its own size limit.
  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned pick;
    int unsigned top;
    int unsigned n;
    int unsigned k;
    logic [7:0]  s;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (pick < 2) write_max_size(8'd4);
      else if (pick < 5) write_max_size(MAX_FRAME_SIZE_RST);
      else write_max_size(8'($urandom_range(5, 254)));
      idling_on = ($urandom_range(3) != 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        top = (max_size_m > 8'd26) ? 26 : max_size_m - 1;
        pick = $urandom_range(99);
        // Mostly short frames; a rare one may use any size the limit allows.
        if (pick < 2) s = 8'($urandom_range(3, max_size_m - 1));
        else s = 8'($urandom_range(3, top));
        if (pick < 75) begin
          send_frame(s, $urandom_range(9) != 0);
        end else if (pick < 85) begin
          send_byte(8'($urandom));
        end else if (pick < 92) begin
          send_byte(s);
          send_byte(8'($urandom));
        end else begin
          // Frame cut short: the following words land in its payload.
          send_byte(s);
          send_byte(~s);
          n = $urandom_range(0, s - 3);
          for (k = 0; k < n; k++) send_byte(8'($urandom));
        end
      end
    end
  endtask

  // Receiver side: random stalls, and one long hold when asked for.
  initial begin : result_sink
    int unsigned stall;
    int unsigned held;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
      end else begin
        if (stall == 0) stall = pick_gap();
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          stall--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare each event word taken from the block with the oldest expected one.
  always @(posedge clk_i) begin : event_check
    lcfr_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $error("event with nothing expected: kind %0d data %02h index %0d length %0d",
               event_kind_o, data_byte_o, byte_index_o, frame_len_o);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, event_kind_o);
          error_count++;
        end
        if (data_byte_o !== want.data_byte) begin
          $error("data_byte: expected %02h, actual %02h", want.data_byte, data_byte_o);
          error_count++;
        end
        if (byte_index_o !== want.byte_index) begin
          $error("byte_index: expected %0d, actual %0d", want.byte_index, byte_index_o);
          error_count++;
        end
        if (frame_len_o !== want.frame_len) begin
          $error("frame_len: expected %0d, actual %0d",
                 want.frame_len, frame_len_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_short_sizes_ignored();
    test_payload_extremes();
    test_oversize_ignored();
    test_complement_mismatch();
    test_min_limit();
    test_long_hold();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("length_checked_frame_receiver: match");
    end else begin
      $display("length_checked_frame_receiver: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("length_checked_frame_receiver: mismatch");
    $finish;
  end

endmodule
